@@ rtl/core/lac_pkg.sv @@
`timescale 1ns / 1ps

package lac_pkg;

	localparam int MAX_LAYERS = 6;
	localparam int CHAN_W     = 8;
	localparam int RGBA_W     = 32;
	localparam int COUNT_W    = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_MASK = 1'b1;

	localparam logic [COUNT_W-1:0]    LAYER_COUNT_RST  = 3'd3;
	localparam logic [MAX_LAYERS-1:0] VISIBLE_MASK_RST = 6'h3f;

	localparam logic [CHAN_W-1:0] BG_ODD_RG   = 8'd48;
	localparam logic [CHAN_W-1:0] BG_ODD_B    = 8'd52;
	localparam logic [CHAN_W-1:0] BG_EVEN_RG  = 8'd36;
	localparam logic [CHAN_W-1:0] BG_EVEN_B   = 8'd40;
	localparam logic [CHAN_W-1:0] ALPHA_FULL  = 8'd255;

	typedef logic [MAX_LAYERS-1:0][RGBA_W-1:0] lac_layers_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		lac_layers_t       layers;
	} lac_word_t;

	// exact x / 255 for x below 65280
	function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
		logic [16:0] t;
		logic [16:0] u;
		t = {1'b0, x} + 17'd1;
		u = t + (t >> 8);
		return u[15:8];
	endfunction

endpackage

@@ rtl/core/layer_alpha_compositor.sv @@
`timescale 1ns / 1ps

// Layer alpha compositor: one canvas pixel in, one opaque RGB pixel out.
// Input: pulse start with pixel_x, pixel_y and the six layer RGBA words;
// the word is taken at any edge where start is high, and busy is always low,
// so a new pixel may enter every cycle.
// Output: done is high for one cycle with out_red/out_green/out_blue valid.
// The receiver cannot stall; every result appears exactly once.
// Pipeline: one entry register that picks the checkerboard colour and gates
// disabled layers, then a row of six blend cells, two register stages each:
// multiply-add, then divide by 255.
// Throughput: one pixel per cycle.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0: layer_count, 1: visible_mask) at the edge; write only while no pixel
// is in flight. Settings are sampled as a pixel enters.
// Reset: clears all in-flight pixels and restores layer_count to 3 and
// visible_mask to all layers visible.
module layer_alpha_compositor
	import lac_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic [8:0]            pixel_x,
	input  logic [7:0]            pixel_y,
	input  logic [RGBA_W-1:0]     layer0_rgba,
	input  logic [RGBA_W-1:0]     layer1_rgba,
	input  logic [RGBA_W-1:0]     layer2_rgba,
	input  logic [RGBA_W-1:0]     layer3_rgba,
	input  logic [RGBA_W-1:0]     layer4_rgba,
	input  logic [RGBA_W-1:0]     layer5_rgba,
	output logic                  done,
	output logic [CHAN_W-1:0]     out_red,
	output logic [CHAN_W-1:0]     out_green,
	output logic [CHAN_W-1:0]     out_blue
);

	logic [COUNT_W-1:0]    layer_count_q;
	logic [MAX_LAYERS-1:0] visible_mask_q;

	lac_layers_t raw_layers;
	lac_layers_t gated_layers;
	logic        odd;
	logic        accept;

	logic      entry_valid_s1;
	lac_word_t entry_s1;

	logic      chain_valid [MAX_LAYERS+1];
	lac_word_t chain_word  [MAX_LAYERS+1];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q  <= LAYER_COUNT_RST;
			visible_mask_q <= VISIBLE_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LAYER_COUNT:  layer_count_q  <= cfg_data[COUNT_W-1:0];
				REG_VISIBLE_MASK: visible_mask_q <= cfg_data[MAX_LAYERS-1:0];
				default: ;
			endcase
		end
	end

	assign raw_layers = {layer5_rgba, layer4_rgba, layer3_rgba,
	                     layer2_rgba, layer1_rgba, layer0_rgba};
	assign odd = pixel_x[3] ^ pixel_y[3];

	// drop a layer by forcing its alpha to zero, which blends as identity
	always_comb begin
		for (int i = 0; i < MAX_LAYERS; i++) begin
			gated_layers[i] = raw_layers[i];
			if (!(COUNT_W'(i) < layer_count_q) || !visible_mask_q[i]) begin
				gated_layers[i][31:24] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_s1 <= 1'b0;
		end else begin
			entry_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		entry_s1.red    <= odd ? BG_ODD_RG : BG_EVEN_RG;
		entry_s1.green  <= odd ? BG_ODD_RG : BG_EVEN_RG;
		entry_s1.blue   <= odd ? BG_ODD_B : BG_EVEN_B;
		entry_s1.layers <= gated_layers;
	end

	assign chain_valid[0] = entry_valid_s1;
	assign chain_word[0]  = entry_s1;

	for (genvar g = 0; g < MAX_LAYERS; g++) begin : g_cell
		lac_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[g]),
			.in_word  (chain_word[g]),
			.out_valid(chain_valid[g+1]),
			.out_word (chain_word[g+1])
		);
	end

	assign done      = chain_valid[MAX_LAYERS];
	assign out_red   = chain_word[MAX_LAYERS].red;
	assign out_green = chain_word[MAX_LAYERS].green;
	assign out_blue  = chain_word[MAX_LAYERS].blue;

endmodule

@@ rtl/core/lac_cell.sv @@
`timescale 1ns / 1ps

module lac_cell
	import lac_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  lac_word_t in_word,
	output logic      out_valid,
	output lac_word_t out_word
);

	logic [CHAN_W-1:0] alpha;
	logic [CHAN_W-1:0] inv;
	logic [RGBA_W-1:0] px;
	logic [15:0]       sum_r;
	logic [15:0]       sum_g;
	logic [15:0]       sum_b;

	logic        valid_s1;
	logic [15:0] red_s1;
	logic [15:0] green_s1;
	logic [15:0] blue_s1;
	lac_layers_t layers_s1;

	logic      valid_s2;
	lac_word_t word_s2;

	always_comb begin
		px    = in_word.layers[0];
		alpha = px[31:24];
		inv   = ALPHA_FULL - alpha;
		sum_r = ({8'd0, in_word.red} * {8'd0, inv}) + ({8'd0, px[7:0]} * {8'd0, alpha});
		sum_g = ({8'd0, in_word.green} * {8'd0, inv}) + ({8'd0, px[15:8]} * {8'd0, alpha});
		sum_b = ({8'd0, in_word.blue} * {8'd0, inv}) + ({8'd0, px[23:16]} * {8'd0, alpha});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		red_s1         <= sum_r;
		green_s1       <= sum_g;
		blue_s1        <= sum_b;
		layers_s1      <= in_word.layers >> RGBA_W;
		word_s2.red    <= div255(red_s1);
		word_s2.green  <= div255(green_s1);
		word_s2.blue   <= div255(blue_s1);
		word_s2.layers <= layers_s1;
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

endmodule

@@ verif/tb_layer_alpha_compositor.sv @@
`timescale 1ns / 1ps

module tb_layer_alpha_compositor;
	import lac_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASES         = 11;
	localparam int PHASE_WORDS    = 180;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  start;
	logic                  busy;
	logic [8:0]            pixel_x;
	logic [7:0]            pixel_y;
	logic [RGBA_W-1:0]     layer0_rgba;
	logic [RGBA_W-1:0]     layer1_rgba;
	logic [RGBA_W-1:0]     layer2_rgba;
	logic [RGBA_W-1:0]     layer3_rgba;
	logic [RGBA_W-1:0]     layer4_rgba;
	logic [RGBA_W-1:0]     layer5_rgba;
	logic                  done;
	logic [CHAN_W-1:0]     out_red;
	logic [CHAN_W-1:0]     out_green;
	logic [CHAN_W-1:0]     out_blue;

	logic [COUNT_W-1:0]    cur_count;
	logic [MAX_LAYERS-1:0] cur_mask;
	rgb_t                  pending_pixels[$];
	int                    mismatches;
	int                    quiet_cycles;

	layer_alpha_compositor uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.layer0_rgba(layer0_rgba),
		.layer1_rgba(layer1_rgba),
		.layer2_rgba(layer2_rgba),
		.layer3_rgba(layer3_rgba),
		.layer4_rgba(layer4_rgba),
		.layer5_rgba(layer5_rgba),
		.done       (done),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] dst,
			input logic [CHAN_W-1:0] src, input logic [CHAN_W-1:0] a);
		int sum;
		sum = int'(dst) * (255 - int'(a)) + int'(src) * int'(a);
		return CHAN_W'(sum / 255);
	endfunction

	function automatic rgb_t blend_pixel(input logic [8:0] x, input logic [7:0] y,
			input lac_layers_t layers, input logic [COUNT_W-1:0] count,
			input logic [MAX_LAYERS-1:0] mask);
		rgb_t              acc;
		logic              odd;
		int                n;
		logic [CHAN_W-1:0] a;
		odd = x[3] ^ y[3];
		acc.red   = odd ? BG_ODD_RG : BG_EVEN_RG;
		acc.green = odd ? BG_ODD_RG : BG_EVEN_RG;
		acc.blue  = odd ? BG_ODD_B : BG_EVEN_B;
		n = (int'(count) > MAX_LAYERS) ? MAX_LAYERS : int'(count);
		for (int i = 0; i < n; i++) begin
			a = layers[i][31:24];
			if (mask[i] && a != 0) begin
				acc.red   = mix_channel(acc.red, layers[i][7:0], a);
				acc.green = mix_channel(acc.green, layers[i][15:8], a);
				acc.blue  = mix_channel(acc.blue, layers[i][23:16], a);
			end
		end
		return acc;
	endfunction

	function automatic lac_layers_t rand_layers();
		lac_layers_t l;
		for (int i = 0; i < MAX_LAYERS; i++) begin
			l[i] = $urandom;
			case ($urandom_range(0, 7))
				0: l[i][31:24] = 8'd0;
				1: l[i][31:24] = ALPHA_FULL;
				default: ;
			endcase
		end
		return l;
	endfunction

	task automatic send_pixel(input logic [8:0] x, input logic [7:0] y,
			input lac_layers_t layers);
		start       <= 1'b1;
		pixel_x     <= x;
		pixel_y     <= y;
		layer0_rgba <= layers[0];
		layer1_rgba <= layers[1];
		layer2_rgba <= layers[2];
		layer3_rgba <= layers[3];
		layer4_rgba <= layers[4];
		layer5_rgba <= layers[5];
		do @(posedge clk); while (busy);
		pending_pixels.push_back(blend_pixel(x, y, layers, cur_count, cur_mask));
	endtask

	task automatic idle_gap(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] count_data,
			input logic [CFG_DATA_W-1:0] mask_data);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_LAYER_COUNT;
		cfg_data  <= count_data;
		@(posedge clk);
		cur_count = count_data[COUNT_W-1:0];
		cfg_index <= REG_VISIBLE_MASK;
		cfg_data  <= mask_data;
		@(posedge clk);
		cur_mask = mask_data[MAX_LAYERS-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_values();
		lac_layers_t l;
		l = {6{32'h80_40_C0_20}};
		send_pixel(9'd5, 8'd9, l);
		l = rand_layers();
		l[3][31:24] = ALPHA_FULL;
		l[5][31:24] = ALPHA_FULL;
		send_pixel(9'd100, 8'd50, l);
	endtask

	task automatic test_checkerboard();
		set_config(6'd0, 6'h3f);
		send_pixel(9'd0, 8'd0, rand_layers());
		send_pixel(9'd8, 8'd0, rand_layers());
		send_pixel(9'd0, 8'd8, rand_layers());
		send_pixel(9'd8, 8'd8, rand_layers());
		send_pixel(9'd7, 8'd7, rand_layers());
		send_pixel(9'd319, 8'd239, rand_layers());
		send_pixel(9'd511, 8'd255, rand_layers());
	endtask

	task automatic test_alpha_extremes();
		lac_layers_t l;
		set_config(6'd6, 6'h3f);
		send_pixel(9'd16, 8'd24, {6{32'h00_FF_FF_FF}});
		send_pixel(9'd24, 8'd24, {6{32'hFF_FF_FF_FF}});
		send_pixel(9'd40, 8'd3, {6{32'h00_00_00_00}});
		l = {6{32'h00_12_34_56}};
		l[0] = 32'hFF_00_00_00;
		l[2] = 32'h01_FF_FF_FF;
		l[4] = 32'hFE_80_7F_01;
		send_pixel(9'd255, 8'd128, l);
		l = {6{32'h01_FF_FF_FF}};
		send_pixel(9'd256, 8'd127, l);
	endtask

	task automatic test_layer_count();
		set_config(6'd7, 6'h3f);
		send_pixel(9'd33, 8'd66, rand_layers());
		send_pixel(9'd200, 8'd199, {6{32'hC0_A5_5A_3C}});
		set_config(6'd1, 6'h3f);
		send_pixel(9'd1, 8'd2, rand_layers());
		send_pixel(9'd320, 8'd240, {6{32'hFF_10_20_30}});
		set_config(6'h3e, 6'h3f);
		send_pixel(9'd150, 8'd90, rand_layers());
		send_pixel(9'd64, 8'd17, {6{32'h7F_FF_00_80}});
	endtask

	task automatic test_visible_mask();
		set_config(6'd6, 6'h00);
		send_pixel(9'd12, 8'd4, {6{32'hFF_FF_FF_FF}});
		send_pixel(9'd300, 8'd230, rand_layers());
		set_config(6'd6, 6'h2a);
		send_pixel(9'd77, 8'd88, {6{32'hFF_00_FF_00}});
		send_pixel(9'd410, 8'd201, rand_layers());
	endtask

	task automatic test_random_phases();
		logic [CFG_DATA_W-1:0] count_data;
		logic [CFG_DATA_W-1:0] mask_data;
		bit                    idle_on;
		for (int p = 0; p < PHASES; p++) begin
			count_data = CFG_DATA_W'($urandom_range(0, 63));
			mask_data  = CFG_DATA_W'($urandom_range(0, 63));
			case (p)
				0: begin count_data = 6'd1; mask_data = 6'h3f; end
				1: begin count_data = 6'd6; mask_data = 6'h00; end
				2: begin count_data = 6'd6; mask_data = 6'h3f; end
				3: count_data = 6'd0;
				4: count_data = 6'd7;
				PHASES - 1: begin count_data = 6'd6; mask_data = 6'h3f; end
				default: ;
			endcase
			set_config(count_data, mask_data);
			idle_on = (p % 3 != 2) && (p != PHASES - 1);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (idle_on && $urandom_range(0, 4) == 0)
					idle_gap($urandom_range(1, 5));
				send_pixel(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
					rand_layers());
			end
		end
	endtask

	always @(posedge clk) begin
		rgb_t want;
		if (done) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected word: out_red %0d out_green %0d out_blue %0d",
					out_red, out_green, out_blue);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (out_red !== want.red) begin
					$error("out_red expected %0d actual %0d", want.red, out_red);
					mismatches++;
				end
				if (out_green !== want.green) begin
					$error("out_green expected %0d actual %0d", want.green, out_green);
					mismatches++;
				end
				if (out_blue !== want.blue) begin
					$error("out_blue expected %0d actual %0d", want.blue, out_blue);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		mismatches   = 0;
		quiet_cycles = 0;
		cur_count    = LAYER_COUNT_RST;
		cur_mask     = VISIBLE_MASK_RST;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_LAYER_COUNT;
		cfg_data    <= '0;
		start       <= 1'b0;
		pixel_x     <= '0;
		pixel_y     <= '0;
		layer0_rgba <= '0;
		layer1_rgba <= '0;
		layer2_rgba <= '0;
		layer3_rgba <= '0;
		layer4_rgba <= '0;
		layer5_rgba <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_checkerboard();
		test_alpha_extremes();
		test_layer_count();
		test_visible_mask();
		test_random_phases();
		drain();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/lac_pkg.sv
rtl/core/lac_cell.sv
rtl/core/layer_alpha_compositor.sv
verif/tb_layer_alpha_compositor.sv
